FILE: sv/rlerc_pkg.sv
// Shared types and constants for the run-length encoder with radix-coded counts.
// No dependencies; imported by the interfaces and by every module of the block.
package rlerc_pkg;

  // Field widths
  localparam int unsigned SampleW   = 32;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned TotalW    = 32;
  localparam int unsigned CfgIdxW   = 4;
  localparam int unsigned CfgDataW  = 32;

  // Default repeat counter width
  localparam int unsigned CountBitsDef = 32;

  // Quotient bits resolved per divider cycle
  localparam int unsigned DivBitsPerCycle = 4;

  // Largest legal data value, whatever max_value says
  localparam logic [ByteW-1:0] DataLimit = 8'd252;

  // Register reset values
  localparam logic [ByteW-1:0]    MaxValueRst    = 8'd252;
  localparam logic [CfgDataW-1:0] OutputLimitRst = 32'hFFFF_FFFF;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegMaxValue    = 4'd0;
  localparam logic [CfgIdxW-1:0] RegOutputLimit = 4'd1;

  // Status codes
  localparam logic [StatusW-1:0] StatusOk    = 2'd0;
  localparam logic [StatusW-1:0] StatusRange = 2'd1;
  localparam logic [StatusW-1:0] StatusFull  = 2'd2;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_FLUSH,
    ST_DIV,
    ST_DIGIT,
    ST_VALUE
  } ctrl_state_e;

  // Kind of result loaded into the output register
  typedef enum logic [2:0] {
    PUT_NONE,
    PUT_VALUE,
    PUT_DIGIT,
    PUT_RANGE,
    PUT_FULL
  } put_e;

  // Controller to datapath
  typedef struct packed {
    logic in_ready;
    logic load_item;
    logic inc_count;
    logic div_start;
    logic div_step;
    put_e put;
    logic put_last;
    logic put_eos;
    logic finish;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_valid;
    logic last;
    logic error_seen;
    logic run_open;
    logic oor;
    logic match;
    logic sat;
    logic count_zero;
    logic quot_zero;
    logic div_last;
    logic full;
    logic can_put;
  } dp_status_t;

endpackage

FILE: sv/rlerc_if.sv
// Handshake channel interfaces: sample requests in, code bytes out, register writes.
// Depends on rlerc_pkg for field widths.
interface rlerc_in_if;
  import rlerc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] sample;
  logic                      last_sample;

  modport source (output valid, sample, last_sample, input ready);
  modport sink   (input valid, sample, last_sample, output ready);
endinterface

interface rlerc_out_if;
  import rlerc_pkg::*;
  logic               valid;
  logic               ready;
  logic [ByteW-1:0]   code_byte;
  logic [StatusW-1:0] status;
  logic               last_of_item;
  logic               end_of_stream;
  logic [TotalW-1:0]  bytes_total;

  modport source (output valid, code_byte, status, last_of_item, end_of_stream, bytes_total,
                  input ready);
  modport sink   (input valid, code_byte, status, last_of_item, end_of_stream, bytes_total,
                  output ready);
endinterface

interface rlerc_cfg_if;
  import rlerc_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/rlerc_ctrl.sv
// Controller state machine of the run-length encoder.
// Depends on rlerc_pkg; drives the datapath through dp_cmd_t, reads dp_status_t.
module rlerc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rlerc_pkg::dp_status_t st_i,
  output rlerc_pkg::dp_cmd_t    cmd_o
);
  import rlerc_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        val_pend_q, val_pend_d;
  logic        digit_final;

  // Final digit of a count that is not followed by a value byte
  assign digit_final = st_i.quot_zero && !val_pend_q;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      val_pend_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      val_pend_q <= val_pend_d;
    end
  end

  // Next state
  always_comb begin
    state_d    = state_q;
    val_pend_d = val_pend_q;
    case (state_q)
      ST_IDLE: begin
        val_pend_d = 1'b0;
        if (st_i.in_valid) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (st_i.error_seen) begin
          state_d = ST_IDLE;
        end else if (st_i.oor) begin
          if (st_i.can_put) state_d = ST_IDLE;
        end else if (!st_i.run_open) begin
          state_d = ST_VALUE;
        end else if (st_i.match && !st_i.sat) begin
          state_d = st_i.last ? ST_FLUSH : ST_IDLE;
        end else begin
          // run ends or counter saturates: digits first, then the value byte
          val_pend_d = 1'b1;
          state_d    = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!st_i.count_zero) state_d = ST_DIV;
        else if (val_pend_q)  state_d = ST_VALUE;
        else                  state_d = ST_IDLE;
      end
      ST_DIV: begin
        if (st_i.div_last) state_d = ST_DIGIT;
      end
      ST_DIGIT: begin
        if (st_i.can_put) begin
          if (st_i.full || digit_final) state_d = ST_IDLE;
          else                          state_d = ST_FLUSH;
        end
      end
      ST_VALUE: begin
        if (st_i.can_put) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd_o = '0;
    cmd_o.put = PUT_NONE;
    case (state_q)
      ST_IDLE: begin
        cmd_o.in_ready  = 1'b1;
        cmd_o.load_item = st_i.in_valid;
      end
      ST_DECIDE: begin
        if (!st_i.error_seen) begin
          if (st_i.oor) begin
            if (st_i.can_put) begin
              cmd_o.put      = PUT_RANGE;
              cmd_o.put_last = 1'b1;
              cmd_o.put_eos  = 1'b1;
            end
          end else if (st_i.run_open && st_i.match && !st_i.sat) begin
            cmd_o.inc_count = 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        cmd_o.div_start = !st_i.count_zero;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      ST_DIGIT: begin
        if (st_i.can_put) begin
          if (st_i.full) begin
            cmd_o.put      = PUT_FULL;
            cmd_o.put_last = 1'b1;
            cmd_o.put_eos  = 1'b1;
          end else begin
            cmd_o.put      = PUT_DIGIT;
            cmd_o.put_last = digit_final;
            cmd_o.put_eos  = digit_final && st_i.last;
            cmd_o.finish   = digit_final && st_i.last;
          end
        end
      end
      ST_VALUE: begin
        if (st_i.can_put) begin
          if (st_i.full) begin
            cmd_o.put      = PUT_FULL;
            cmd_o.put_last = 1'b1;
            cmd_o.put_eos  = 1'b1;
          end else begin
            cmd_o.put      = PUT_VALUE;
            cmd_o.put_last = 1'b1;
            cmd_o.put_eos  = st_i.last;
            cmd_o.finish   = st_i.last;
          end
        end
      end
      default: ;
    endcase
  end

  // Results are only loaded when the output register can take them
  a_put_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.put != PUT_NONE) |-> st_i.can_put)
    else $error("result loaded into a full output register");

  // A digit is emitted only after a division pass
  a_digit_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIGIT && $past(state_q) != ST_DIGIT) |-> $past(state_q) == ST_DIV)
    else $error("digit state entered without division");

  // Pending value flag belongs to the current request only
  a_pend_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DECIDE) |-> !val_pend_q)
    else $error("stale pending value flag");

endmodule

FILE: sv/rlerc_dp.sv
// Datapath: config registers, run state, shared radix divider and output register.
// Depends on rlerc_pkg and the rlerc_*_if interfaces; steered by rlerc_ctrl.
module rlerc_dp #(
  parameter int unsigned COUNT_BITS = rlerc_pkg::CountBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  rlerc_in_if.sink              in_i,
  rlerc_out_if.source           out_o,
  rlerc_cfg_if.sink             cfg_i,
  input  rlerc_pkg::dp_cmd_t    cmd_i,
  output rlerc_pkg::dp_status_t st_o
);
  import rlerc_pkg::*;

  localparam int unsigned DivSteps = (COUNT_BITS + DivBitsPerCycle - 1) / DivBitsPerCycle;
  localparam int unsigned DivW     = DivSteps * DivBitsPerCycle;
  localparam int unsigned StepW    = (DivSteps > 1) ? $clog2(DivSteps) : 1;

  // Config registers
  logic [ByteW-1:0]    max_value_q;
  logic [CfgDataW-1:0] output_limit_q;

  // Current request
  logic signed [SampleW-1:0] sample_q;
  logic                      last_q;

  // Run state
  logic [ByteW-1:0]      run_value_q;
  logic [COUNT_BITS-1:0] count_q;
  logic                  run_open_q;
  logic [TotalW-1:0]     bytes_q;
  logic                  error_q;

  // Divider
  logic [DivW-1:0]  quo_q, quo_nx;
  logic [ByteW-1:0] rem_q, rem_nx;
  logic [ByteW:0]   part;
  logic [StepW-1:0] step_q;

  // Output register
  logic               out_valid_q;
  logic [ByteW-1:0]   code_q;
  logic [StatusW-1:0] status_q;
  logic               last_of_item_q;
  logic               eos_q;
  logic [TotalW-1:0]  total_q;

  logic [ByteW-1:0] m_eff;
  logic [ByteW-1:0] radix;
  logic [ByteW-1:0] digit_code;
  logic             can_put;
  logic             put_byte;

  // Effective max value and count radix (at least 3)
  assign m_eff      = (max_value_q > DataLimit) ? DataLimit : max_value_q;
  assign radix      = 8'd255 - m_eff;
  assign digit_code = rem_q + m_eff + 8'd1;
  assign can_put    = !out_valid_q || out_o.ready;
  assign put_byte   = (cmd_i.put == PUT_VALUE) || (cmd_i.put == PUT_DIGIT);

  // Status to the controller
  always_comb begin
    st_o.in_valid   = in_i.valid;
    st_o.last       = last_q;
    st_o.error_seen = error_q;
    st_o.run_open   = run_open_q;
    st_o.oor        = $unsigned(sample_q) > {{(SampleW-ByteW){1'b0}}, m_eff};
    st_o.match      = sample_q[ByteW-1:0] == run_value_q;
    st_o.sat        = &count_q;
    st_o.count_zero = count_q == '0;
    st_o.quot_zero  = quo_q == '0;
    st_o.div_last   = step_q == StepW'(DivSteps - 1);
    st_o.full       = bytes_q == output_limit_q;
    st_o.can_put    = can_put;
  end

  assign in_i.ready  = cmd_i.in_ready;
  assign cfg_i.ready = 1'b1;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_value_q    <= MaxValueRst;
      output_limit_q <= OutputLimitRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        RegMaxValue:    max_value_q    <= cfg_i.data[ByteW-1:0];
        RegOutputLimit: output_limit_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      sample_q <= in_i.sample;
      last_q   <= in_i.last_sample;
    end
  end

  // Run state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_value_q <= '0;
      count_q     <= '0;
      run_open_q  <= 1'b0;
      bytes_q     <= '0;
      error_q     <= 1'b0;
    end else begin
      if (cmd_i.put == PUT_RANGE || cmd_i.put == PUT_FULL) error_q <= 1'b1;
      if (cmd_i.put == PUT_VALUE) begin
        run_value_q <= sample_q[ByteW-1:0];
        run_open_q  <= 1'b1;
      end
      if (cmd_i.inc_count) count_q <= count_q + 1'b1;
      if (cmd_i.put == PUT_DIGIT) count_q <= quo_q[COUNT_BITS-1:0];
      if (cmd_i.put == PUT_VALUE) count_q <= '0;
      if (put_byte) bytes_q <= bytes_q + 1'b1;
      // end of stream: next sample opens a new one
      if (cmd_i.finish) begin
        run_open_q <= 1'b0;
        count_q    <= '0;
        bytes_q    <= '0;
      end
    end
  end

  // Divider step: DivBitsPerCycle restoring steps on a narrow remainder
  always_comb begin
    quo_nx = quo_q;
    rem_nx = rem_q;
    part   = '0;
    for (int i = 0; i < DivBitsPerCycle; i++) begin
      part   = {rem_nx, quo_nx[DivW-1]};
      quo_nx = {quo_nx[DivW-2:0], 1'b0};
      if (part >= {1'b0, radix}) begin
        rem_nx    = ByteW'(part - {1'b0, radix});
        quo_nx[0] = 1'b1;
      end else begin
        rem_nx = part[ByteW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      quo_q <= DivW'(count_q);
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q <= quo_nx;
      rem_q <= rem_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cmd_i.div_start) begin
      step_q <= '0;
    end else if (cmd_i.div_step) begin
      step_q <= step_q + 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.put != PUT_NONE) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.put != PUT_NONE) begin
      last_of_item_q <= cmd_i.put_last;
      eos_q          <= cmd_i.put_eos;
      case (cmd_i.put)
        PUT_VALUE: begin
          code_q   <= sample_q[ByteW-1:0];
          status_q <= StatusOk;
          total_q  <= bytes_q + 1'b1;
        end
        PUT_DIGIT: begin
          code_q   <= digit_code;
          status_q <= StatusOk;
          total_q  <= bytes_q + 1'b1;
        end
        PUT_RANGE: begin
          code_q   <= '0;
          status_q <= StatusRange;
          total_q  <= bytes_q;
        end
        default: begin
          code_q   <= '0;
          status_q <= StatusFull;
          total_q  <= bytes_q;
        end
      endcase
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.code_byte     = code_q;
  assign out_o.status        = status_q;
  assign out_o.last_of_item  = last_of_item_q;
  assign out_o.end_of_stream = eos_q;
  assign out_o.bytes_total   = total_q;

  // A completed stream restarts its byte count
  a_stream_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (put_byte && cmd_i.finish) |=> (bytes_q == '0 && !run_open_q))
    else $error("stream end did not clear byte count");

  // An aborted stream stays aborted until reset
  a_error_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    error_q |=> error_q)
    else $error("abort flag cleared");

  // Digit bytes stay above the value range
  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.put == PUT_DIGIT) |-> (digit_code > m_eff))
    else $error("digit byte inside value range");

endmodule

FILE: sv/run_length_encoder_radix_counts.sv
// Top level of the run-length encoder with radix-coded repeat counts.
// Depends on rlerc_pkg, rlerc_if.sv, rlerc_ctrl and rlerc_dp.
//
//   Port    Dir   Carries                               Request taken when
//   in_i    in    sample, last_sample                   in_i.valid && in_i.ready
//   out_o   out   code_byte, status, last_of_item,      out_o.valid && out_o.ready
//                 end_of_stream, bytes_total
//   cfg_i   in    index, data (0 max_value,             cfg_i.valid && cfg_i.ready
//                 1 output_limit)
//
// A repeat of the open run or an out-of-range sample passes IDLE and DECIDE; a first sample
// also passes VALUE. Each repeat-count digit passes FLUSH, DIV and DIGIT: the shared divider
// resolves 4 quotient bits a cycle; a value byte after digits passes FLUSH and VALUE. One
// request is worked at a time; in_i.ready is high only between requests. Output stalls hold
// the controller only when a new result meets a full output register. Reset clears control,
// config, run and output-valid state at once; no clearing pass. cfg_i.ready is always 1.
module run_length_encoder_radix_counts #(
  parameter int unsigned COUNT_BITS = rlerc_pkg::CountBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rlerc_in_if.sink    in_i,
  rlerc_out_if.source out_o,
  rlerc_cfg_if.sink   cfg_i
);
  import rlerc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;

  rlerc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .st_i   (st),
    .cmd_o  (cmd)
  );

  rlerc_dp #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .out_o  (out_o),
    .cfg_i  (cfg_i),
    .cmd_i  (cmd),
    .st_o   (st)
  );

endmodule
